/* rtl/core/tce_pkg.sv */
// Shared types, codes and decode table of the toy CPU execute unit.
`timescale 1ns / 1ps
`default_nettype none
package tce_pkg;

  // Operation codes
  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_MOV  = 5'd1;
  localparam logic [4:0] OP_PUSH = 5'd2;
  localparam logic [4:0] OP_POP  = 5'd3;
  localparam logic [4:0] OP_ADD  = 5'd4;
  localparam logic [4:0] OP_SUB  = 5'd5;
  localparam logic [4:0] OP_MUL  = 5'd6;
  localparam logic [4:0] OP_DIV  = 5'd7;
  localparam logic [4:0] OP_CMP  = 5'd8;
  localparam logic [4:0] OP_JMP  = 5'd9;
  localparam logic [4:0] OP_JEQ  = 5'd10;
  localparam logic [4:0] OP_CALL = 5'd11;
  localparam logic [4:0] OP_RET  = 5'd12;
  localparam logic [4:0] OP_RST  = 5'd13;
  localparam logic [4:0] OP_HLT  = 5'd14;
  localparam logic [4:0] OP_LDR  = 5'd15;
  localparam logic [4:0] OP_STR  = 5'd16;
  localparam logic [4:0] OP_LAST = 5'd16;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_ADDR   = 3'd2;
  localparam logic [2:0] ST_BADOP  = 3'd3;
  localparam logic [2:0] ST_IRQ    = 3'd4;

  // Addressing modes
  localparam logic AM_IMM = 1'b0;
  localparam logic AM_REG = 1'b1;

  localparam logic [63:0] STACK_TOP  = 64'd8000;
  localparam logic [63:0] STACK_STEP = 64'd8;

  // Operand usage of each operation
  typedef struct packed {
    logic src_rd;
    logic dst_rd;
    logic dst_wr;
  } op_use_t;

  function automatic op_use_t op_use(input logic [4:0] op);
    op_use_t u;
    u = '0;
    unique case (op)
      OP_MOV:  u = '{src_rd: 1'b1, dst_rd: 1'b0, dst_wr: 1'b1};
      OP_PUSH: u = '{src_rd: 1'b0, dst_rd: 1'b1, dst_wr: 1'b0};
      OP_POP:  u = '{src_rd: 1'b0, dst_rd: 1'b0, dst_wr: 1'b1};
      OP_ADD, OP_SUB, OP_MUL, OP_DIV:
               u = '{src_rd: 1'b1, dst_rd: 1'b1, dst_wr: 1'b1};
      OP_CMP:  u = '{src_rd: 1'b1, dst_rd: 1'b1, dst_wr: 1'b0};
      OP_JMP, OP_JEQ, OP_CALL:
               u = '{src_rd: 1'b0, dst_rd: 1'b1, dst_wr: 1'b0};
      OP_LDR:  u = '{src_rd: 1'b0, dst_rd: 1'b0, dst_wr: 1'b1};
      OP_STR:  u = '{src_rd: 1'b1, dst_rd: 1'b0, dst_wr: 1'b0};
      default: u = '0;
    endcase
    return u;
  endfunction

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [63:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/tce_if.sv */
// Instruction and result channel interfaces of the execute unit.
`timescale 1ns / 1ps
`default_nettype none
interface tce_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic        src_addressing;
  logic        dest_addressing;
  logic [63:0] src_value;
  logic [63:0] dest_value;
  logic        interrupt_pending;

  modport source (output valid, mode, src_addressing, dest_addressing, src_value,
                  dest_value, interrupt_pending, input ready);
  modport sink   (input valid, mode, src_addressing, dest_addressing, src_value,
                  dest_value, interrupt_pending, output ready);
endinterface

interface tce_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] result_value;
  logic [63:0] next_pc;
  logic        zero_flag;

  modport source (output valid, status, result_value, next_pc, zero_flag, input ready);
  modport sink   (input valid, status, result_value, next_pc, zero_flag, output ready);
endinterface
`default_nettype wire

/* rtl/core/tce_div.sv */
// Iterative 64-bit unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tce_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tce_pkg::div_req_t req,
  output tce_pkg::div_rsp_t  rsp
);

  logic [6:0]  count;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic        done;

  logic [64:0] shifted;
  logic [64:0] diff;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[63]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        count <= 7'd64;
      end else if (count != 7'd0) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (count != 7'd0) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

/* rtl/core/toy_cpu_execute_unit_core.sv */
// Top level of the toy CPU execute unit: sequencer, register file and word memory.
`timescale 1ns / 1ps
`default_nettype none
// One decoded instruction is taken at a time and gives one result transfer. The next
// instruction is taken at the earliest in the cycle after the result enters the output
// register. mul uses one 32x32 multiplier three times. div waits for the divider to
// work out the quotient, unless the divisor is zero. For push, call and str, and for
// pop, ret and ldr, the word address is reduced modulo MEMORY_WORDS four bits a cycle,
// and the memory is written or read after that. A result that has not been taken holds
// the next finished instruction, and the input waits behind it. The register file and
// the word memory are synchronous memories with registered read data. After reset the
// word memory is cleared, one word a cycle, before the first instruction is taken. Once
// halted, interrupted or given an unknown opcode, the unit answers every later
// instruction with status halted until reset.
module toy_cpu_execute_unit_core #(
  parameter int MEMORY_WORDS   = 8192,
  parameter int REGISTER_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  tce_in_if.sink    instr,
  tce_out_if.source result
);

  localparam int RW = $clog2(REGISTER_COUNT);
  localparam int MW = $clog2(MEMORY_WORDS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_MRD   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state;

  // architectural state
  logic [63:0] pc;
  logic [63:0] sp;
  logic        flag;
  logic        stopped;

  // latched instruction
  logic [4:0]  op;
  logic        sam;
  logic        dam;
  logic [63:0] sv;
  logic [63:0] dv;
  logic        irq;

  // operands and pending result
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] mem_wd;
  logic [2:0]  st_q;
  logic [63:0] res_q;
  logic [MW-1:0] clr_cnt;

  // multiplier
  logic [1:0]  mul_step;
  logic [63:0] mul_p;
  logic [63:0] mul_lo;
  logic [31:0] mul_hi;
  logic [31:0] mul_x;
  logic [31:0] mul_y;

  // word address reduction
  logic          mod_start;
  logic [63:0]   mod_addr;
  logic [63:0]   mod_x;
  logic [MW-1:0] mod_r;
  logic [4:0]    mod_cnt;
  logic [MW+3:0] mod_t;
  logic [MW+3:0] mod_sub;
  logic [MW+3:0] mod_rem;
  logic          mod_done;

  // output register
  logic        out_valid;
  logic [2:0]  out_status;
  logic [63:0] out_result;
  logic [63:0] out_pc;
  logic        out_flag;

  // register file
  logic [63:0] rf [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_vld;
  logic [63:0] rf_rs_q;
  logic [63:0] rf_rd_q;
  logic        rf_we;
  logic [RW-1:0] rf_wa;
  logic [63:0] rf_wd;
  logic        rf_clear;

  // word memory
  logic [63:0] mem [MEMORY_WORDS];
  logic [63:0] mem_q;
  logic        mem_we;
  logic [MW-1:0] mem_addr;
  logic [63:0] mem_wdata;

  tce_pkg::div_req_t div_req;
  tce_pkg::div_rsp_t div_rsp;

  tce_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // operand fetch and decode
  tce_pkg::op_use_t use_bits;
  logic        known;
  logic        err;
  logic        go;
  logic [63:0] a_val;
  logic [63:0] b_val;
  logic [63:0] pc_inc;
  logic        is_mem_wr;
  logic        is_mem_op;

  always_comb begin
    use_bits = tce_pkg::op_use(op);
    known    = (op <= tce_pkg::OP_LAST);
    err      = (use_bits.src_rd && sam == tce_pkg::AM_REG && sv >= 64'(REGISTER_COUNT)) ||
               (use_bits.dst_rd && dam == tce_pkg::AM_REG && dv >= 64'(REGISTER_COUNT)) ||
               (use_bits.dst_wr && (dam == tce_pkg::AM_IMM || dv >= 64'(REGISTER_COUNT)));
    go       = !stopped && !irq && known && !err;
    pc_inc   = pc + 64'd1;
    if (sam == tce_pkg::AM_IMM) begin
      a_val = sv;
    end else begin
      a_val = (sv != 64'd0 && rf_vld[sv[RW-1:0]]) ? rf_rs_q : 64'd0;
    end
    if (dam == tce_pkg::AM_IMM) begin
      b_val = dv;
    end else begin
      b_val = (dv != 64'd0 && rf_vld[dv[RW-1:0]]) ? rf_rd_q : 64'd0;
    end
    is_mem_wr = (op == tce_pkg::OP_PUSH) || (op == tce_pkg::OP_CALL) ||
                (op == tce_pkg::OP_STR);
    is_mem_op = is_mem_wr || (op == tce_pkg::OP_POP) || (op == tce_pkg::OP_RET) ||
                (op == tce_pkg::OP_LDR);
  end

  // divider request for the arithmetic divide
  always_comb begin
    div_req = '0;
    if (state == S_EXEC && go && op == tce_pkg::OP_DIV && b_val != 64'd0) begin
      div_req.start    = 1'b1;
      div_req.dividend = a_val;
      div_req.divisor  = b_val;
    end
  end

  // word address of the stack or load/store access
  always_comb begin
    mod_start = (state == S_EXEC) && go && is_mem_op;
    priority case (op)
      tce_pkg::OP_POP, tce_pkg::OP_RET: mod_addr = sp + tce_pkg::STACK_STEP;
      tce_pkg::OP_LDR:                  mod_addr = sv;
      tce_pkg::OP_STR:                  mod_addr = dv;
      default:                          mod_addr = sp;
    endcase
  end

  // one radix-16 digit of the reduction: subtract the largest fitting multiple
  always_comb begin
    mod_t   = {mod_r, mod_x[63:60]};
    mod_sub = '0;
    for (int k = 1; k < 16; k++) begin
      if (mod_t >= (MW+4)'(k * MEMORY_WORDS)) begin
        mod_sub = (MW+4)'(k * MEMORY_WORDS);
      end
    end
    mod_rem  = mod_t - mod_sub;
    mod_done = (state == S_MOD) && (mod_cnt == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= 5'd0;
    end else if (mod_start) begin
      mod_cnt <= 5'd16;
    end else if (mod_cnt != 5'd0) begin
      mod_cnt <= mod_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_start) begin
      mod_x <= mod_addr;
      mod_r <= '0;
    end else if (mod_cnt != 5'd0) begin
      mod_x <= {mod_x[59:0], 4'd0};
      mod_r <= mod_rem[MW-1:0];
    end
  end

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_wd    = 64'd0;
    rf_clear = (state == S_EXEC) && go && (op == tce_pkg::OP_RST);
    unique case (state)
      S_EXEC: begin
        if (go) begin
          priority case (op)
            tce_pkg::OP_MOV: begin rf_we = 1'b1; rf_wd = a_val; end
            tce_pkg::OP_ADD: begin rf_we = 1'b1; rf_wd = b_val + a_val; end
            tce_pkg::OP_SUB: begin rf_we = 1'b1; rf_wd = b_val - a_val; end
            tce_pkg::OP_DIV: begin rf_we = (b_val == 64'd0); rf_wd = '1; end
            default: rf_we = 1'b0;
          endcase
        end
      end
      S_MUL: begin
        rf_we = (mul_step == 2'd3);
        rf_wd = mul_lo + {mul_hi + mul_p[31:0], 32'd0};
      end
      S_DIV: begin
        rf_we = div_rsp.done;
        rf_wd = div_rsp.quotient;
      end
      S_MRD: begin
        rf_we = (op == tce_pkg::OP_POP) || (op == tce_pkg::OP_LDR);
        rf_wd = mem_q;
      end
      default: rf_we = 1'b0;
    endcase
    rf_we = rf_we && (dv != 64'd0);
    rf_wa = dv[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    rf_rs_q <= rf[instr.src_value[RW-1:0]];
    rf_rd_q <= rf[instr.dest_value[RW-1:0]];
  end

  // per-entry valid bits stand for the all-zero reset of the register file
  always_ff @(posedge clk) begin
    if (rst || rf_clear) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_wa] <= 1'b1;
    end
  end

  // word memory port: clearing pass, then stack and load/store accesses
  always_comb begin
    mem_we    = (state == S_CLEAR) || (mod_done && is_mem_wr);
    mem_addr  = (state == S_CLEAR) ? clr_cnt : mod_r;
    mem_wdata = (state == S_CLEAR) ? 64'd0 : mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  // shared 32x32 multiplier, one partial product a cycle
  always_comb begin
    unique case (mul_step)
      2'd0:    begin mul_x = opa[31:0];  mul_y = opb[31:0];  end
      2'd1:    begin mul_x = opa[31:0];  mul_y = opb[63:32]; end
      2'd2:    begin mul_x = opa[63:32]; mul_y = opb[31:0];  end
      default: begin mul_x = 32'd0;      mul_y = 32'd0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_x * mul_y;
    if (state == S_MUL) begin
      if (mul_step == 2'd1) mul_lo <= mul_p;
      if (mul_step == 2'd2) mul_hi <= mul_p[31:0];
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      pc        <= 64'd0;
      sp        <= tce_pkg::STACK_TOP;
      flag      <= 1'b0;
      stopped   <= 1'b0;
      mul_step  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + MW'(1);
          if (clr_cnt == MW'(MEMORY_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (instr.valid) begin
            op    <= instr.mode;
            sam   <= instr.src_addressing;
            dam   <= instr.dest_addressing;
            sv    <= instr.src_value;
            dv    <= instr.dest_value;
            irq   <= instr.interrupt_pending;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          opa   <= a_val;
          opb   <= b_val;
          st_q  <= tce_pkg::ST_OK;
          res_q <= 64'd0;
          state <= S_DONE;
          if (stopped) begin
            st_q <= tce_pkg::ST_HALT;
          end else if (irq) begin
            stopped <= 1'b1;
            st_q    <= tce_pkg::ST_IRQ;
          end else begin
            pc <= pc_inc;
            if (!known) begin
              stopped <= 1'b1;
              st_q    <= tce_pkg::ST_BADOP;
            end else if (err) begin
              st_q <= tce_pkg::ST_ADDR;
            end else begin
              priority case (op)
                tce_pkg::OP_MOV: res_q <= a_val;
                tce_pkg::OP_ADD: res_q <= b_val + a_val;
                tce_pkg::OP_SUB: res_q <= b_val - a_val;
                tce_pkg::OP_MUL: begin
                  mul_step <= 2'd0;
                  state    <= S_MUL;
                end
                tce_pkg::OP_DIV: begin
                  if (b_val == 64'd0) begin
                    res_q <= '1;
                  end else begin
                    state <= S_DIV;
                  end
                end
                tce_pkg::OP_CMP: begin
                  flag  <= (a_val == b_val);
                  res_q <= {63'd0, a_val == b_val};
                end
                tce_pkg::OP_JMP: begin
                  pc    <= b_val;
                  res_q <= b_val;
                end
                tce_pkg::OP_JEQ: begin
                  pc    <= flag ? b_val : pc_inc;
                  res_q <= flag ? b_val : pc_inc;
                end
                tce_pkg::OP_PUSH: begin
                  mem_wd <= b_val;
                  res_q  <= b_val;
                  sp     <= sp - tce_pkg::STACK_STEP;
                  state  <= S_MOD;
                end
                tce_pkg::OP_CALL: begin
                  mem_wd <= pc_inc;
                  res_q  <= b_val;
                  pc     <= b_val;
                  sp     <= sp - tce_pkg::STACK_STEP;
                  state  <= S_MOD;
                end
                tce_pkg::OP_STR: begin
                  mem_wd <= a_val;
                  res_q  <= a_val;
                  state  <= S_MOD;
                end
                tce_pkg::OP_POP, tce_pkg::OP_RET: begin
                  sp    <= sp + tce_pkg::STACK_STEP;
                  state <= S_MOD;
                end
                tce_pkg::OP_LDR: state <= S_MOD;
                tce_pkg::OP_RST: begin
                  pc   <= 64'd0;
                  sp   <= tce_pkg::STACK_TOP;
                  flag <= 1'b0;
                end
                tce_pkg::OP_HLT: begin
                  stopped <= 1'b1;
                  st_q    <= tce_pkg::ST_HALT;
                end
                default: res_q <= 64'd0;
              endcase
            end
          end
        end
        S_MUL: begin
          mul_step <= mul_step + 2'd1;
          if (mul_step == 2'd3) begin
            res_q <= rf_wd;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q <= div_rsp.quotient;
            state <= S_DONE;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= is_mem_wr ? S_DONE : S_MRD;
          end
        end
        S_MRD: begin
          res_q <= mem_q;
          if (op == tce_pkg::OP_RET) begin
            pc <= mem_q;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= st_q;
            out_result <= res_q;
            out_pc     <= pc;
            out_flag   <= flag;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign instr.ready         = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.result_value = out_result;
  assign result.next_pc      = out_pc;
  assign result.zero_flag    = out_flag;

`ifndef ASSERT_OFF
  a_div_start_exec: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> state == S_EXEC)
    else $error("divider started outside execute");
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> dv != 64'd0)
    else $error("write to register zero");
  a_stopped_sticks: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stopped cleared without reset");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !instr.ready)
    else $error("instruction taken during memory clear");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

/* sim/toy_cpu_execute_unit_core_tb.sv */
// Self-checking testbench of the toy CPU execute unit: directed and random instruction streams against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module toy_cpu_execute_unit_core_tb;

  localparam int MEM_WORDS  = 8192;
  localparam int REG_COUNT  = 64;
  localparam int IDLE_LIMIT = 40000;
  localparam int RAND_ITEMS = 1700;

  typedef struct {
    logic [4:0]  mode;
    logic        src_am;
    logic        dst_am;
    logic [63:0] src_val;
    logic [63:0] dst_val;
    logic        irq;
  } instr_t;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] value;
    logic [63:0] pc;
    logic        zf;
  } exec_result_t;

  // Architectural state copy and queue of expected execution results
  class tce_scoreboard;
    logic [63:0]  regs [REG_COUNT];
    logic [63:0]  mem [MEM_WORDS];
    logic [63:0]  pc, sp, ra;
    logic         eq_flag, stopped;
    exec_result_t expected_q[$];
    int           errors;

    function new();
      foreach (mem[k]) mem[k] = '0;
      stopped = 1'b0;
      errors  = 0;
      clear_core();
    endfunction

    function void clear_core();
      foreach (regs[k]) regs[k] = '0;
      pc      = '0;
      sp      = tce_pkg::STACK_TOP;
      ra      = '0;
      eq_flag = 1'b0;
    endfunction

    function logic [63:0] operand(logic am, logic [63:0] v);
      if (am == tce_pkg::AM_IMM) return v;
      if (v == 0 || v >= REG_COUNT) return '0;
      return regs[v];
    endfunction

    function void write_reg(logic [63:0] n, logic [63:0] v);
      if (n != 0 && n < REG_COUNT) regs[n] = v;
    endfunction

    // Execute one accepted instruction and queue what the unit must return
    function void note_instruction(instr_t i);
      exec_result_t r;
      logic rd_src, rd_dst, wr_dst, err;
      logic [63:0] a, b;
      r.status = tce_pkg::ST_OK;
      r.value  = '0;
      rd_src = 1'b0;
      rd_dst = 1'b0;
      wr_dst = 1'b0;
      if (stopped) begin
        r.status = tce_pkg::ST_HALT;
      end else if (i.irq) begin
        stopped  = 1'b1;
        r.status = tce_pkg::ST_IRQ;
      end else begin
        pc = pc + 64'd1;
        if (i.mode > tce_pkg::OP_LAST) begin
          stopped  = 1'b1;
          r.status = tce_pkg::ST_BADOP;
        end else begin
          case (i.mode)
            tce_pkg::OP_MOV: begin rd_src = 1'b1; wr_dst = 1'b1; end
            tce_pkg::OP_PUSH, tce_pkg::OP_JMP, tce_pkg::OP_JEQ, tce_pkg::OP_CALL:
              rd_dst = 1'b1;
            tce_pkg::OP_POP, tce_pkg::OP_LDR: wr_dst = 1'b1;
            tce_pkg::OP_ADD, tce_pkg::OP_SUB, tce_pkg::OP_MUL, tce_pkg::OP_DIV: begin
              rd_src = 1'b1; rd_dst = 1'b1; wr_dst = 1'b1;
            end
            tce_pkg::OP_CMP: begin rd_src = 1'b1; rd_dst = 1'b1; end
            tce_pkg::OP_STR: rd_src = 1'b1;
            default: ;
          endcase
          err = (rd_src && i.src_am && i.src_val >= REG_COUNT) ||
                (rd_dst && i.dst_am && i.dst_val >= REG_COUNT) ||
                (wr_dst && (i.dst_am == tce_pkg::AM_IMM || i.dst_val >= REG_COUNT));
          if (err) begin
            r.status = tce_pkg::ST_ADDR;
          end else begin
            a = operand(i.src_am, i.src_val);
            b = operand(i.dst_am, i.dst_val);
            case (i.mode)
              tce_pkg::OP_MOV: begin r.value = a; write_reg(i.dst_val, a); end
              tce_pkg::OP_PUSH: begin
                r.value = b;
                mem[sp % MEM_WORDS] = b;
                sp = sp - tce_pkg::STACK_STEP;
              end
              tce_pkg::OP_POP: begin
                sp = sp + tce_pkg::STACK_STEP;
                r.value = mem[sp % MEM_WORDS];
                write_reg(i.dst_val, r.value);
              end
              tce_pkg::OP_ADD: begin r.value = b + a; write_reg(i.dst_val, r.value); end
              tce_pkg::OP_SUB: begin r.value = b - a; write_reg(i.dst_val, r.value); end
              tce_pkg::OP_MUL: begin r.value = b * a; write_reg(i.dst_val, r.value); end
              tce_pkg::OP_DIV: begin
                r.value = (b == 0) ? '1 : a / b;
                write_reg(i.dst_val, r.value);
              end
              tce_pkg::OP_CMP: begin eq_flag = (a == b); r.value = {63'd0, eq_flag}; end
              tce_pkg::OP_JMP: begin pc = b; r.value = b; end
              tce_pkg::OP_JEQ: begin
                if (eq_flag) pc = b;
                r.value = pc;
              end
              tce_pkg::OP_CALL: begin
                ra = pc;
                mem[sp % MEM_WORDS] = ra;
                sp = sp - tce_pkg::STACK_STEP;
                pc = b;
                r.value = b;
              end
              tce_pkg::OP_RET: begin
                sp = sp + tce_pkg::STACK_STEP;
                pc = mem[sp % MEM_WORDS];
                ra = '0;
                r.value = pc;
              end
              tce_pkg::OP_RST: clear_core();
              tce_pkg::OP_HLT: begin stopped = 1'b1; r.status = tce_pkg::ST_HALT; end
              tce_pkg::OP_LDR: begin
                r.value = mem[i.src_val % MEM_WORDS];
                write_reg(i.dst_val, r.value);
              end
              tce_pkg::OP_STR: begin r.value = a; mem[i.dst_val % MEM_WORDS] = a; end
              default: ;
            endcase
          end
        end
      end
      r.pc = pc;
      r.zf = eq_flag;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    // Compare one result transfer with the oldest expectation
    task check_result(exec_result_t got);
      exec_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", {61'd0, got.status}, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) report("status", {61'd0, got.status}, {61'd0, want.status});
        if (got.value !== want.value) report("result_value", got.value, want.value);
        if (got.pc !== want.pc) report("next_pc", got.pc, want.pc);
        if (got.zf !== want.zf) report("zero_flag", {63'd0, got.zf}, {63'd0, want.zf});
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  tce_in_if  instr_ch ();
  tce_out_if result_ch ();
  tce_scoreboard sb;
  instr_t directed_q[$];
  int idle_cycles = 0;

  toy_cpu_execute_unit_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch.sink),
    .result (result_ch.source)
  );

  always #4 clk = ~clk;

  function automatic instr_t mk(logic [4:0] m, logic sa, logic da, logic [63:0] s,
                                logic [63:0] d);
    instr_t i;
    i.mode = m; i.src_am = sa; i.dst_am = da; i.src_val = s; i.dst_val = d; i.irq = 1'b0;
    return i;
  endfunction

  function automatic logic [63:0] rand_reg();
    case ($urandom_range(0, 19))
      0: return 64'(REG_COUNT + $urandom_range(0, 100));
      1: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, REG_COUNT - 1));
    endcase
  endfunction

  function automatic logic [63:0] rand_imm();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 3));
      1: return '1;
      2: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Memory addresses cluster near the stack and low words so loads hit stored data
  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 63));
      1: return 64'($urandom_range(7900, 8008));
      2: return 64'(MEM_WORDS) * $urandom_range(0, 7) + $urandom_range(0, 15);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t i;
    do i.mode = 5'($urandom_range(0, tce_pkg::OP_LAST)); while (i.mode == tce_pkg::OP_HLT ||
        (i.mode == tce_pkg::OP_RST && $urandom_range(0, 9) != 0));
    i.src_am  = 1'($urandom_range(0, 1));
    i.dst_am  = ($urandom_range(0, 9) != 0) ? tce_pkg::AM_REG : tce_pkg::AM_IMM;
    i.src_val = i.src_am ? rand_reg() : rand_imm();
    i.dst_val = i.dst_am ? rand_reg() : rand_imm();
    if (i.mode == tce_pkg::OP_LDR) i.src_val = rand_addr();
    if (i.mode == tce_pkg::OP_STR) i.dst_val = rand_addr();
    i.irq = 1'b0;
    return i;
  endfunction

  // Offer one instruction after a random gap and hold it until the transfer
  task send_instr(instr_t i);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid             <= 1'b1;
    instr_ch.mode              <= i.mode;
    instr_ch.src_addressing    <= i.src_am;
    instr_ch.dest_addressing   <= i.dst_am;
    instr_ch.src_value         <= i.src_val;
    instr_ch.dest_value        <= i.dst_val;
    instr_ch.interrupt_pending <= i.irq;
    do @(posedge clk); while (!instr_ch.ready);
    sb.note_instruction(i);
  endtask

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    exec_result_t got;
    int gap, n;
    result_ch.ready = 1'b0;
    n = 0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (n == 300) gap = 600;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got.status = result_ch.status;
      got.value  = result_ch.result_value;
      got.pc     = result_ch.next_pc;
      got.zf     = result_ch.zero_flag;
      sb.check_result(got);
      n++;
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    instr_t i;
    int kind;
    rst = 1'b1;
    instr_ch.valid = 1'b0;
    instr_ch.mode = '0;
    instr_ch.src_addressing = 1'b0;
    instr_ch.dest_addressing = 1'b0;
    instr_ch.src_value = '0;
    instr_ch.dest_value = '0;
    instr_ch.interrupt_pending = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: each operation but halt, register zero, divide by zero, addressing errors
    directed_q.push_back(mk(tce_pkg::OP_NOP, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, '0));
    directed_q.push_back(mk(tce_pkg::OP_MOV, tce_pkg::AM_IMM, tce_pkg::AM_REG, '1, 64'd1));
    directed_q.push_back(mk(tce_pkg::OP_MOV, tce_pkg::AM_REG, tce_pkg::AM_REG, 64'd1, 64'd0));
    directed_q.push_back(mk(tce_pkg::OP_MOV, tce_pkg::AM_IMM, tce_pkg::AM_REG, 64'd7, 64'd63));
    directed_q.push_back(mk(tce_pkg::OP_ADD, tce_pkg::AM_REG, tce_pkg::AM_REG, 64'd1, 64'd63));
    directed_q.push_back(mk(tce_pkg::OP_SUB, tce_pkg::AM_IMM, tce_pkg::AM_REG, 64'd9, 64'd63));
    directed_q.push_back(mk(tce_pkg::OP_MUL, tce_pkg::AM_REG, tce_pkg::AM_REG, 64'd1, 64'd1));
    directed_q.push_back(mk(tce_pkg::OP_DIV, tce_pkg::AM_IMM, tce_pkg::AM_REG, 64'd100, 64'd2));
    directed_q.push_back(mk(tce_pkg::OP_MOV, tce_pkg::AM_IMM, tce_pkg::AM_REG, 64'd3, 64'd4));
    directed_q.push_back(mk(tce_pkg::OP_DIV, tce_pkg::AM_IMM, tce_pkg::AM_REG, 64'd100, 64'd4));
    directed_q.push_back(mk(tce_pkg::OP_CMP, tce_pkg::AM_IMM, tce_pkg::AM_IMM, 64'd5, 64'd5));
    directed_q.push_back(mk(tce_pkg::OP_JEQ, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, 64'd40));
    directed_q.push_back(mk(tce_pkg::OP_CMP, tce_pkg::AM_REG, tce_pkg::AM_IMM, 64'd0, 64'd5));
    directed_q.push_back(mk(tce_pkg::OP_JEQ, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, 64'd80));
    directed_q.push_back(mk(tce_pkg::OP_JEQ, tce_pkg::AM_IMM, tce_pkg::AM_REG, '0, 64'd100));
    directed_q.push_back(mk(tce_pkg::OP_JMP, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, '1));
    directed_q.push_back(mk(tce_pkg::OP_CALL, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, 64'd500));
    directed_q.push_back(mk(tce_pkg::OP_PUSH, tce_pkg::AM_IMM, tce_pkg::AM_REG, '0, 64'd63));
    directed_q.push_back(mk(tce_pkg::OP_POP, tce_pkg::AM_IMM, tce_pkg::AM_REG, '0, 64'd5));
    directed_q.push_back(mk(tce_pkg::OP_RET, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, '0));
    directed_q.push_back(mk(tce_pkg::OP_STR, tce_pkg::AM_REG, tce_pkg::AM_IMM, 64'd63, '1));
    directed_q.push_back(mk(tce_pkg::OP_LDR, tce_pkg::AM_IMM, tce_pkg::AM_REG, '1, 64'd6));
    directed_q.push_back(mk(tce_pkg::OP_ADD, tce_pkg::AM_REG, tce_pkg::AM_REG, 64'd64, 64'd1));
    directed_q.push_back(mk(tce_pkg::OP_MOV, tce_pkg::AM_IMM, tce_pkg::AM_IMM, 64'd1, 64'd1));
    directed_q.push_back(mk(tce_pkg::OP_RST, tce_pkg::AM_IMM, tce_pkg::AM_IMM, '0, '0));
    foreach (directed_q[k]) send_instr(directed_q[k]);

    // Random instruction stream, with one drain pause midway
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 900) begin
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
      end
      send_instr(rand_instr());
    end

    // One stop event (interrupt, halt or unknown opcode), then the stopped unit
    kind = $urandom_range(0, 2);
    i = rand_instr();
    if (kind == 0) i.irq = 1'b1;
    else if (kind == 1) i.mode = tce_pkg::OP_HLT;
    else i.mode = 5'($urandom_range(tce_pkg::OP_LAST + 1, 31));
    send_instr(i);
    for (int k = 0; k < 6; k++) begin
      i = rand_instr();
      i.irq = 1'($urandom_range(0, 1));
      if (k == 0) i.mode = 5'($urandom_range(tce_pkg::OP_LAST + 1, 31));
      if (k == 1) i.mode = tce_pkg::OP_HLT;
      send_instr(i);
    end
    instr_ch.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
